FILE: src/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg: shared types and constants of the residual norm engine
// Sizes of the stores, widths of the datapath and the codes of the command
// and configuration ports.
// ----------------------------------------------------------------------------
`default_nettype none

package rne_pkg;

  localparam int MAX_DIM = 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = 5;
  localparam int AW      = $clog2(MAX_DIM * MAX_DIM);
  localparam int VAL_W   = 8;
  localparam int PROD_W  = 2 * VAL_W;

  // Largest row residual magnitude is MAX_DIM * 128 * 128 + 128.
  localparam int D_W     = $clog2(MAX_DIM * 16384 + 129) + 1;
  localparam int MAG_W   = D_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ACC_W   = SQ_W + $clog2(MAX_DIM);
  localparam int FRAC_W  = 8;
  localparam int RAD_W   = ACC_W + 2 * FRAC_W;
  localparam int ROOT_W  = (RAD_W + 1) / 2;
  localparam int RW2     = 2 * ROOT_W;
  localparam int NORM_W  = 29;

  localparam logic [NORM_W-1:0] NORM_MAX  = '1;
  localparam logic [CNT_W-1:0]  DIM_RESET = CNT_W'(16);

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_WRITE_X = 2'd2,
    OP_NORM    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROOT
  } st_t;

  // Bookkeeping that travels with each product through the MAC pipeline.
  typedef struct packed {
    logic             first;
    logic             last;
    logic             zero;
    logic [IDX_W-1:0] row;
  } tag_t;

endpackage

`default_nettype wire

FILE: src/rne_ram.sv
// ----------------------------------------------------------------------------
// rne_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/rne_sqrt.sv
// ----------------------------------------------------------------------------
// rne_sqrt: iterative integer square root
// Restoring square root that settles one result bit per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [rne_pkg::RAD_W-1:0]  radicand,
  output logic                            done,
  output logic      [rne_pkg::ROOT_W-1:0] root
);

  import rne_pkg::*;

  logic           running;
  logic [RW2-1:0] rem;
  logic [RW2-1:0] res;
  logic [RW2-1:0] probe;
  logic [RW2-1:0] trial;
  logic           fits;

  assign trial = res + probe;
  assign fits  = rem >= trial;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && probe[0]) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem   <= RW2'(radicand);
      res   <= '0;
      probe <= RW2'(1) << (RW2 - 2);
    end else if (running) begin
      if (fits) begin
        rem <= rem - trial;
        res <= (res >> 1) + probe;
      end else begin
        res <= res >> 1;
      end
      probe <= probe >> 2;
    end
  end

endmodule

`default_nettype wire

FILE: src/residual_norm_engine.sv
// ----------------------------------------------------------------------------
// residual_norm_engine: Euclidean norm of the residual A*x - b
// Loads A, b and x one element per command word and computes the norm on
// request as unsigned fixed point with 8 fraction bits.
// ----------------------------------------------------------------------------
// A write word (op 0, 1 or 2) is taken without raising busy, so loads can
// stream at one word per clock while no compute is running. A compute word
// raises busy until the norm is ready, and skips the multiply-accumulate
// pipeline when no rows are in use. One matrix element per cycle (one per
// row when no columns are in use) passes through the single pipeline, which
// then drains. The 58-bit radicand then goes through the square-root unit,
// which settles one result bit per cycle and hands the root over. The result
// appears on norm_fixed with done high for exactly one cycle, the cycle in
// which busy falls; the receiver cannot stall it, and it must be taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module residual_norm_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 op,
  input  wire logic [3:0]                 row_index,
  input  wire logic [3:0]                 col_index,
  input  wire logic signed [7:0]          value,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic [rne_pkg::CNT_W-1:0]  cfg_data,
  output logic                            done,
  output logic      [rne_pkg::NORM_W-1:0] norm_fixed
);

  import rne_pkg::*;

  st_t state, state_next;

  logic [CNT_W-1:0] num_rows;
  logic [CNT_W-1:0] num_cols;
  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] cols_eff;

  logic             accept;
  logic             compute_go;
  logic             issue;
  logic             sqrt_go;
  logic             pipe_empty;
  logic             last_col;
  logic             last_row;
  logic [IDX_W-1:0] row_cnt;
  logic [IDX_W-1:0] col_cnt;

  logic signed [VAL_W-1:0] b_store [MAX_DIM];
  logic signed [VAL_W-1:0] x_store [MAX_DIM];

  logic             a_we;
  logic [AW-1:0]    a_waddr;
  logic [AW-1:0]    a_raddr;
  logic [VAL_W-1:0] a_rdata;

  // Pipeline: s1 = RAM read, s2 = product, s3 = row residual, s4 = square.
  logic                     s1_valid, s2_valid, s3_valid, s4_valid;
  tag_t                     s1_tag, s2_tag;
  logic signed [VAL_W-1:0]  s1_x;
  logic signed [PROD_W-1:0] prod;
  logic signed [D_W-1:0]    resid;
  logic signed [D_W-1:0]    resid_base;
  logic signed [D_W-1:0]    resid_abs;
  logic [MAG_W-1:0]         resid_mag;
  logic [SQ_W-1:0]          square;
  logic [ACC_W-1:0]         acc;

  logic              root_done;
  logic [ROOT_W-1:0] root;

  assign accept     = start && !busy;
  assign compute_go = accept && (op_t'(op) == OP_NORM);

  always_comb begin
    rows_eff = (int'(num_rows) > MAX_DIM) ? CNT_W'(MAX_DIM) : num_rows;
    cols_eff = (int'(num_cols) > MAX_DIM) ? CNT_W'(MAX_DIM) : num_cols;
  end

  assign last_col   = (cols_eff == '0) || (CNT_W'(col_cnt) == cols_eff - CNT_W'(1));
  assign last_row   = CNT_W'(row_cnt) == rows_eff - CNT_W'(1);
  assign pipe_empty = !s1_valid && !s2_valid && !s3_valid && !s4_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_RESET;
      num_cols <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROWS: num_rows <= cfg_data;
        CFG_COLS: num_cols <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (compute_go) begin
          state_next = (rows_eff == '0) ? ST_DRAIN : ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_col && last_row) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = state != ST_IDLE;
    issue   = state == ST_MAC;
    sqrt_go = (state == ST_DRAIN) && pipe_empty;
  end

  always_ff @(posedge clk) begin
    if (compute_go) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (issue) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + IDX_W'(1);
      end else begin
        col_cnt <= col_cnt + IDX_W'(1);
      end
    end
  end

  // Stores.
  assign a_we    = accept && (op_t'(op) == OP_WRITE_A) &&
                   (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
  assign a_waddr = AW'(row_index) * AW'(MAX_DIM) + AW'(col_index);
  assign a_raddr = AW'(row_cnt) * AW'(MAX_DIM) + AW'(col_cnt);

  rne_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_matrix (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept && (op_t'(op) == OP_WRITE_B) && (int'(row_index) < MAX_DIM)) begin
      b_store[IDX_W'(row_index)] <= value;
    end
    if (accept && (op_t'(op) == OP_WRITE_X) && (int'(col_index) < MAX_DIM)) begin
      x_store[IDX_W'(col_index)] <= value;
    end
  end

  // Multiply-accumulate pipeline, control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      acc      <= '0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_tag.last;
      s4_valid <= s3_valid;
      if (compute_go) begin
        acc <= '0;
      end else if (s4_valid) begin
        acc <= acc + ACC_W'(square);
      end
    end
  end

  // A row's residual starts from -b and collects one product per cycle.
  always_comb begin
    resid_base = s2_tag.first ? -D_W'(b_store[s2_tag.row]) : resid;
    resid_abs  = (resid < 0) ? -resid : resid;
    resid_mag  = resid_abs[MAG_W-1:0];
  end

  // Multiply-accumulate pipeline, data.
  always_ff @(posedge clk) begin
    s1_tag.first <= col_cnt == '0;
    s1_tag.last  <= last_col;
    s1_tag.zero  <= cols_eff == '0;
    s1_tag.row   <= row_cnt;
    s1_x         <= x_store[col_cnt];

    s2_tag <= s1_tag;
    if (s1_tag.zero) begin
      prod <= '0;
    end else begin
      prod <= $signed(a_rdata) * s1_x;
    end

    if (s2_valid) begin
      resid <= resid_base + D_W'(prod);
    end

    square <= resid_mag * resid_mag;
  end

  rne_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (sqrt_go),
    .radicand ({acc, (2 * FRAC_W)'(0)}),
    .done     (root_done),
    .root     (root)
  );

  // Result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= root_done;
    end
  end

  always_ff @(posedge clk) begin
    if (root_done) begin
      norm_fixed <= (root > ROOT_W'(NORM_MAX)) ? NORM_MAX : NORM_W'(root);
    end
  end

endmodule

`default_nettype wire
